### rtl/core/aip_pkg.sv
package aip_pkg;

	// Result codes
	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_BAD   = 3'd2,
		ST_OVF   = 3'd3,
		ST_SIGN  = 3'd4,
		ST_UNF   = 3'd5
	} aip_status_t;

	// Target type codes
	localparam logic [1:0] MODE_U32 = 2'd0;
	localparam logic [1:0] MODE_S32 = 2'd1;
	localparam logic [1:0] MODE_U64 = 2'd2;
	localparam logic [1:0] MODE_S64 = 2'd3;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} aip_base_t;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	typedef struct packed {
		logic [7:0] ch;
		logic [1:0] mode;
	} aip_item_t;

	typedef struct packed {
		logic [63:0] value;
		aip_status_t status;
	} aip_result_t;

	// Outcome of one digit step
	typedef struct packed {
		logic bad;
		logic ovf;
	} aip_digit_flags_t;

endpackage

### rtl/core/aip_digit.sv
module aip_digit (
	input  logic [63:0]              acc,
	input  logic [7:0]               ch,
	input  aip_pkg::aip_base_t       base,
	output logic [63:0]              acc_next,
	output aip_pkg::aip_digit_flags_t flags
);

	logic [3:0]  digit;
	logic        is_digit;
	logic [67:0] scaled;
	logic [67:0] sum;

	// Decode the character as a digit of the current base
	always_comb begin
		digit    = ch[3:0];
		is_digit = 1'b0;
		if (ch >= aip_pkg::CH_0 && ch <= aip_pkg::CH_9) begin
			is_digit = (base != aip_pkg::BASE_OCT) || (ch <= aip_pkg::CH_7);
		end else if (base == aip_pkg::BASE_HEX &&
				((ch >= aip_pkg::CH_LA && ch <= aip_pkg::CH_LF) ||
				 (ch >= aip_pkg::CH_UA && ch <= aip_pkg::CH_UF))) begin
			is_digit = 1'b1;
			digit    = 4'(ch[3:0] + 4'd9);
		end
	end

	// Scale by the base with shifts; carry bits above 64 flag overflow
	always_comb begin
		case (base)
			aip_pkg::BASE_HEX: scaled = {acc, 4'b0000};
			aip_pkg::BASE_OCT: scaled = {1'b0, acc, 3'b000};
			default:           scaled = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
		endcase
		sum = scaled + {64'd0, digit};
	end

	assign acc_next  = sum[63:0];
	assign flags.bad = !is_digit;
	assign flags.ovf = |sum[67:64];

endmodule

### rtl/core/aip_finish.sv
module aip_finish (
	input  logic [63:0]           acc,
	input  logic                  negative,
	input  logic                  empty,
	input  aip_pkg::aip_status_t  err,
	input  logic [1:0]            mode,
	output aip_pkg::aip_result_t  result
);

	logic wide;
	logic above_min;
	logic above_max;

	assign wide = (mode == aip_pkg::MODE_U64) || (mode == aip_pkg::MODE_S64);

	// Signed limits: magnitude above 2^(n-1) for negatives, at or above it otherwise
	always_comb begin
		if (wide) begin
			above_min = acc[63] && (|acc[62:0]);
			above_max = acc[63];
		end else begin
			above_min = (|acc[63:32]) || (acc[31] && (|acc[30:0]));
			above_max = |acc[63:31];
		end
	end

	always_comb begin
		result.value  = 64'd0;
		result.status = aip_pkg::ST_OK;
		if (empty) begin
			result.status = aip_pkg::ST_EMPTY;
		end else if (err != aip_pkg::ST_OK) begin
			result.status = err;
		end else if (!mode[0]) begin
			if (negative) begin
				result.status = aip_pkg::ST_SIGN;
			end else if (!wide && (|acc[63:32])) begin
				result.status = aip_pkg::ST_OVF;
			end else begin
				result.value = acc;
			end
		end else if (negative) begin
			if (above_min) begin
				result.status = aip_pkg::ST_UNF;
			end else begin
				result.value = 64'd0 - acc;
			end
		end else if (above_max) begin
			result.status = aip_pkg::ST_OVF;
		end else begin
			result.value = acc;
		end
	end

endmodule

### rtl/core/ascii_integer_parser_top.sv
// ASCII integer parser. Feed a number one character per request on the item
// channel and end it with a NUL character; the NUL request alone produces one
// result on the result channel, carrying the 64-bit value and a status
// (ok, empty, bad digit, overflow, sign not allowed, underflow). A leading '-'
// is accepted; "0x" selects hex (digits of either case), a leading '0' octal,
// anything else decimal. The mode field of the NUL request picks the target
// type (u32, s32, u64, s64) and the range check; signed values come out
// sign-extended, and the value is zero whenever status is not ok. After the
// first error, characters up to the NUL are ignored. Throughput is one
// character per clock unless the output stalls: each request is held in the
// input register, where a single shift-and-add step of the 64-bit accumulator
// handles it, and the result of the NUL request is registered in the output
// register. The input stalls only while a result sits unclaimed in the output
// register and another request waits behind it.
module ascii_integer_parser_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  aip_pkg::aip_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output aip_pkg::aip_result_t result
);

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_SIGN  = 3'd1,
		PH_ZERO  = 3'd2,
		PH_HEX   = 3'd3,
		PH_OCT   = 3'd4,
		PH_DEC   = 3'd5
	} phase_t;

	// Input register
	logic                 valid_s1;
	aip_pkg::aip_item_t   item_s1;

	// Parse state
	phase_t               phase_q;
	logic [63:0]          acc_q;
	logic                 neg_q;
	aip_pkg::aip_status_t err_q;

	// Output register
	logic                 out_valid_q;
	aip_pkg::aip_result_t result_q;

	logic                 advance;
	logic                 is_nul;

	phase_t               phase_d;
	logic [63:0]          acc_d;
	logic                 neg_d;
	aip_pkg::aip_status_t err_d;

	aip_pkg::aip_base_t        base;
	logic                      take;
	logic [63:0]               acc_step;
	aip_pkg::aip_digit_flags_t flags;
	aip_pkg::aip_result_t      fin;

	// Advance the held request whenever the output register is free or draining
	assign advance    = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign is_nul     = (item_s1.ch == aip_pkg::CH_NUL);

	aip_digit u_digit (
		.acc      (acc_q),
		.ch       (item_s1.ch),
		.base     (base),
		.acc_next (acc_step),
		.flags    (flags)
	);

	aip_finish u_finish (
		.acc      (acc_q),
		.negative (neg_q),
		.empty    (phase_q == PH_START),
		.err      (err_q),
		.mode     (item_s1.mode),
		.result   (fin)
	);

	// Next parse state for the held character
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		err_d   = err_q;
		base    = aip_pkg::BASE_DEC;
		take    = 1'b0;
		if (is_nul) begin
			// Terminator: drop all state back to start of string
			phase_d = PH_START;
			acc_d   = 64'd0;
			neg_d   = 1'b0;
			err_d   = aip_pkg::ST_OK;
		end else if (err_q == aip_pkg::ST_OK) begin
			if (phase_q == PH_START && item_s1.ch == aip_pkg::CH_MINUS) begin
				neg_d   = 1'b1;
				phase_d = PH_SIGN;
			end else begin
				unique case (phase_q)
					PH_START, PH_SIGN: begin
						if (item_s1.ch == aip_pkg::CH_0) begin
							phase_d = PH_ZERO;
						end else begin
							phase_d = PH_DEC;
							take    = 1'b1;
						end
					end
					PH_ZERO: begin
						if (item_s1.ch == aip_pkg::CH_LX) begin
							phase_d = PH_HEX;
						end else begin
							phase_d = PH_OCT;
							base    = aip_pkg::BASE_OCT;
							take    = 1'b1;
						end
					end
					PH_HEX: begin
						base = aip_pkg::BASE_HEX;
						take = 1'b1;
					end
					PH_OCT: begin
						base = aip_pkg::BASE_OCT;
						take = 1'b1;
					end
					default: begin
						phase_d = PH_DEC;
						take    = 1'b1;
					end
				endcase
				if (take) begin
					if (flags.bad) begin
						err_d = aip_pkg::ST_BAD;
					end else if (flags.ovf) begin
						err_d = aip_pkg::ST_OVF;
					end else begin
						acc_d = acc_step;
					end
				end
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_START;
			acc_q       <= 64'd0;
			neg_q       <= 1'b0;
			err_q       <= aip_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				neg_q   <= neg_d;
				err_q   <= err_d;
			end
			if (advance && is_nul) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold the request and the finished result
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (advance && is_nul) begin
			result_q <= fin;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

### rtl/core/aip_checker.sv
module aip_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input aip_pkg::aip_item_t   item,
	input logic                 result_valid,
	input logic                 result_ready,
	input aip_pkg::aip_result_t result
);

	// Any failure status carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != aip_pkg::ST_OK) |-> (result.value == 64'd0))
		else $error("nonzero value with failure status");

	// Status codes stay within the defined set
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status <= aip_pkg::ST_UNF))
		else $error("undefined status code");

	// Input backpressure only while a result waits unclaimed
	assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> (result_valid && !result_ready))
		else $error("input stalled without output backpressure");

	// A stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// A waiting request holds until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("request changed while waiting");

endmodule

bind ascii_integer_parser_top aip_checker u_aip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
